>>> hdl/backing_store_map_table_defines.svh
// Assertion macros for the backing store map table.
`ifndef BACKING_STORE_MAP_TABLE_DEFINES_SVH
`define BACKING_STORE_MAP_TABLE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BSMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BSMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bsmt_pkg.sv
package bsmt_pkg;

	localparam int STORES     = 8;
	localparam int STORE_W    = $clog2(STORES);
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam int CMD_W    = 3;
	localparam int IDX_W    = 3;
	localparam int PID_W    = 6;
	localparam int VADDR_W  = 32;
	localparam int PAGE_W   = 20;
	localparam int COUNT_W  = 8;
	localparam int OFFSET_W = 21;

	localparam int IN_W  = 72;
	localparam int OUT_W = 32;

	localparam logic [PAGE_W-1:0] RESET_PAGE = PAGE_W'(4096);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC    = 3'd0,
		CMD_FREE     = 3'd1,
		CMD_LOOKUP   = 3'd2,
		CMD_MAP      = 3'd3,
		CMD_UNMAP    = 3'd4,
		CMD_MARK_PRV = 3'd5
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_status_t;

endpackage

>>> hdl/bsmt_ctrl.sv
module bsmt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  bsmt_pkg::dp_status_t  status,
	output bsmt_pkg::ctl_cmd_t    cmd
);

	bsmt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsmt_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = bsmt_pkg::ST_EXEC;
			end
			bsmt_pkg::ST_EXEC: begin
				if (!status.out_blocked) state_d = bsmt_pkg::ST_IDLE;
			end
			default: state_d = bsmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			bsmt_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			bsmt_pkg::ST_EXEC: begin
				// hold the command until the result register can take its answer
				cmd.execute = !status.out_blocked;
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/bsmt_datapath.sv
module bsmt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bsmt_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bsmt_pkg::OUT_W-1:0]    m_tdata,
	input  bsmt_pkg::ctl_cmd_t            cmd,
	output bsmt_pkg::dp_status_t          status
);

	localparam int SW = bsmt_pkg::STORE_W;

	// captured command
	logic [bsmt_pkg::CMD_W-1:0]   cmd_q;
	logic [bsmt_pkg::IDX_W-1:0]   idx_q;
	logic [bsmt_pkg::PID_W-1:0]   pid_q;
	logic [bsmt_pkg::VADDR_W-1:0] vaddr_q;
	logic [bsmt_pkg::PAGE_W-1:0]  spage_q;

	// map table
	logic [bsmt_pkg::STORES-1:0]  mapped_q;
	logic [bsmt_pkg::STORES-1:0]  priv_q;
	logic [bsmt_pkg::PID_W-1:0]   owner_q [bsmt_pkg::STORES];
	logic [bsmt_pkg::PAGE_W-1:0]  first_q [bsmt_pkg::STORES];

	// result register
	logic                            out_valid_q;
	logic                            ok_q;
	logic [bsmt_pkg::IDX_W-1:0]      store_q;
	logic [bsmt_pkg::OFFSET_W-1:0]   offset_q;

	logic                            free_hit, own_hit, idx_ok, refused;
	logic [SW-1:0]                   free_idx, own_idx, idx_w;
	logic                            res_ok;
	logic [bsmt_pkg::IDX_W-1:0]      res_store;
	logic [bsmt_pkg::OFFSET_W-1:0]   res_offset;
	logic [bsmt_pkg::VADDR_W-1:0]    vpage;
	bsmt_pkg::cmd_t                  op;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= s_tdata[2:0];
			idx_q   <= s_tdata[5:3];
			pid_q   <= s_tdata[11:6];
			vaddr_q <= s_tdata[43:12];
			spage_q <= s_tdata[63:44];
		end
	end

	assign op     = bsmt_pkg::cmd_t'(cmd_q);
	assign idx_ok = (32'(idx_q) < bsmt_pkg::STORES);
	assign idx_w  = SW'(idx_q);
	assign vpage  = vaddr_q >> bsmt_pkg::PAGE_SHIFT;

	// lowest unmapped store and lowest store mapped to the pid
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		own_hit  = 1'b0;
		own_idx  = '0;
		for (int i = bsmt_pkg::STORES - 1; i >= 0; i--) begin
			if (!mapped_q[i]) begin
				free_hit = 1'b1;
				free_idx = SW'(i);
			end
			if (mapped_q[i] && owner_q[i] == pid_q) begin
				own_hit = 1'b1;
				own_idx = SW'(i);
			end
		end
	end

	assign refused = priv_q[idx_w] && (!mapped_q[idx_w] || owner_q[idx_w] != pid_q);

	always_comb begin
		res_ok     = 1'b0;
		res_store  = '0;
		res_offset = '0;
		unique case (op)
			bsmt_pkg::CMD_ALLOC: begin
				res_ok    = free_hit;
				res_store = free_hit ? bsmt_pkg::IDX_W'(free_idx) : '0;
			end
			bsmt_pkg::CMD_FREE:     res_ok = idx_ok && mapped_q[idx_w];
			bsmt_pkg::CMD_LOOKUP: begin
				res_ok = own_hit;
				if (own_hit) begin
					res_store  = bsmt_pkg::IDX_W'(own_idx);
					res_offset = bsmt_pkg::OFFSET_W'(vpage
						- bsmt_pkg::VADDR_W'(first_q[own_idx]));
				end
			end
			bsmt_pkg::CMD_MAP:      res_ok = idx_ok && !refused;
			bsmt_pkg::CMD_UNMAP:    res_ok = own_hit;
			bsmt_pkg::CMD_MARK_PRV: res_ok = idx_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q    <= '0;
			priv_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < bsmt_pkg::STORES; i++) begin
				owner_q[i] <= '0;
				first_q[i] <= bsmt_pkg::RESET_PAGE;
			end
		end else begin
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
				unique case (op)
					bsmt_pkg::CMD_FREE: begin
						if (idx_ok && mapped_q[idx_w]) begin
							mapped_q[idx_w] <= 1'b0;
							priv_q[idx_w]   <= 1'b0;
							owner_q[idx_w]  <= '0;
							first_q[idx_w]  <= bsmt_pkg::RESET_PAGE;
						end
					end
					bsmt_pkg::CMD_MAP: begin
						if (idx_ok && !refused) begin
							mapped_q[idx_w] <= 1'b1;
							owner_q[idx_w]  <= pid_q;
							first_q[idx_w]  <= spage_q;
						end
					end
					bsmt_pkg::CMD_UNMAP: begin
						if (own_hit) begin
							mapped_q[own_idx] <= 1'b0;
							priv_q[own_idx]   <= 1'b0;
							owner_q[own_idx]  <= '0;
							first_q[own_idx]  <= bsmt_pkg::RESET_PAGE;
						end
					end
					bsmt_pkg::CMD_MARK_PRV: begin
						if (idx_ok) priv_q[idx_w] <= 1'b1;
					end
					default: ;
				endcase
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			ok_q     <= res_ok;
			store_q  <= res_store;
			offset_q <= res_offset;
		end
	end

	assign status.out_blocked = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, offset_q, store_q, ok_q};

endmodule

>>> hdl/backing_store_map_table.sv
// Channel   Dir  Payload (lowest bit first)
// s_*       in   command[3] store_index[3] pid[6] vaddr[32] start_page[20] page_count[8]
// m_*       out  ok[1] found_store[3] page_offset[21] zero[7]
//
// A command is captured in the idle state; the execute state then searches the
// eight flop entries in parallel, updates the table and loads the result.
// The result register frees the input side: a new command is taken while
// an answer waits, and only the update cycle waits on a full result register.
// arst_n clears the table to all unmapped, first page 4096, no private marks.
module backing_store_map_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command, store_index, pid, vaddr, start_page, page_count
	input  logic [bsmt_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ok, found_store, page_offset, zero padding
	output logic [bsmt_pkg::OUT_W-1:0]    m_tdata
);

	bsmt_pkg::ctl_cmd_t   cmd;
	bsmt_pkg::dp_status_t status;

	bsmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bsmt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

>>> hdl/bsmt_checker.sv
`include "backing_store_map_table_defines.svh"

module bsmt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [bsmt_pkg::IN_W-1:0]     s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bsmt_pkg::OUT_W-1:0]    m_tdata
);

	// a stalled result stays put
	`BSMT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// one command at a time: the input closes after each transaction
	`BSMT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "input open during execution")

	// failing results carry no store and no offset
	`BSMT_ASSERT_NOW(a_fail_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[24:1] == 24'd0, "failing result not cleared")

	// a fresh result follows a command taken in the idle state and run in the execute state
	`BSMT_ASSERT_NOW(a_no_phantom, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without command")

endmodule

bind backing_store_map_table bsmt_checker u_bsmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
